// ----- rtl/core/wtdp_pkg.sv -----
package wtdp_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int CordicStepsMax     = 32;

    localparam logic [7:0] FRAME_START = 8'h53;
    localparam logic [7:0] FRAME_END   = 8'h45;
    localparam logic [7:0] CMD_MOVE    = 8'h01;

    localparam logic [7:0] REG_TURN_MS  = 8'd0;
    localparam logic [7:0] REG_DRIVE_MS = 8'd1;

    localparam logic [9:0]  TURN_MS_RESET  = 10'd10;
    localparam logic [15:0] DRIVE_MS_RESET = 16'd1000;
    localparam logic [15:0] POS_X_RESET    = 16'd0;
    localparam logic [15:0] POS_Y_RESET    = 16'd320;
    localparam logic signed [15:0] HEAD_RESET = 16'sd9000;

    // 90 degrees in 2^-16 centidegree units
    localparam logic signed [32:0] Z_MAX = 33'sd589824000;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  command_code;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [7:0]  end_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] rotation_cdeg;
        logic [15:0]        turn_ms;
        logic [31:0]        drive_ms;
        logic signed [15:0] new_heading_cdeg;
    } out_item_t;

    // start / done pair between the sequencer and each iterative unit
    typedef struct packed {
        logic start;
    } unit_cmd_t;

    typedef struct packed {
        logic done;
    } unit_sts_t;

    // atan(2^-i) in 2^-16 centidegree units
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'd294912000;
                5'd1:  v = 32'd174096719;
                5'd2:  v = 32'd91987925;
                5'd3:  v = 32'd46694507;
                5'd4:  v = 32'd23437865;
                5'd5:  v = 32'd11730358;
                5'd6:  v = 32'd5866610;
                5'd7:  v = 32'd2933484;
                5'd8:  v = 32'd1466764;
                5'd9:  v = 32'd733385;
                5'd10: v = 32'd366693;
                5'd11: v = 32'd183346;
                5'd12: v = 32'd91673;
                5'd13: v = 32'd45837;
                5'd14: v = 32'd22918;
                5'd15: v = 32'd11459;
                5'd16: v = 32'd5730;
                5'd17: v = 32'd2865;
                5'd18: v = 32'd1432;
                5'd19: v = 32'd716;
                5'd20: v = 32'd358;
                5'd21: v = 32'd179;
                5'd22: v = 32'd90;
                5'd23: v = 32'd45;
                5'd24: v = 32'd22;
                5'd25: v = 32'd11;
                5'd26: v = 32'd6;
                5'd27: v = 32'd3;
                5'd28: v = 32'd1;
                5'd29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/wtdp_cordic.sv -----
module wtdp_cordic #(
    parameter int CORDIC_STEPS = wtdp_pkg::CordicStepsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wtdp_pkg::unit_cmd_t cmd,
    input  logic [15:0]        mag_x,
    input  logic [15:0]        mag_y,
    output wtdp_pkg::unit_sts_t sts,
    output logic [13:0]        angle_cdeg
);
    import wtdp_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic signed [34:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic signed [34:0] xs, ys;
    logic signed [32:0] zc, zr;

    always_comb
    begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (cmd.start)
        begin
            x_next   = $signed({5'd0, mag_x, 14'd0});
            y_next   = $signed({5'd0, mag_y, 14'd0});
            z_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (cnt_reg == CW'(CORDIC_STEPS))
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + $signed({1'b0, atan_entry(5'(cnt_reg))});
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - $signed({1'b0, atan_entry(5'(cnt_reg))});
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // clamp to [0, 90 deg], round half up to centidegrees
    always_comb
    begin
        if (z_reg < 0)
            zc = '0;
        else if (z_reg > Z_MAX)
            zc = Z_MAX;
        else
            zc = z_reg;
        zr = zc + 33'sd32768;
        angle_cdeg = zr[29:16];
    end

    assign sts.done = !run_reg;

endmodule

// ----- rtl/core/wtdp_isqrt.sv -----
module wtdp_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  wtdp_pkg::unit_cmd_t cmd,
    input  logic [63:0]        radicand,
    output wtdp_pkg::unit_sts_t sts,
    output logic [31:0]        root
);
    import wtdp_pkg::*;

    logic [63:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic        run_reg, run_next;
    logic [63:0] trial;

    always_comb
    begin
        trial    = res_reg + bit_reg;
        v_next   = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        run_next = run_reg;
        if (cmd.start)
        begin
            v_next   = radicand;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (bit_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (v_reg >= trial)
                begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root     = res_reg[31:0];
    assign sts.done = !run_reg;

endmodule

// ----- rtl/core/wtdp_div100.sv -----
module wtdp_div100 (
    input  logic               clk,
    input  logic               rst_n,
    input  wtdp_pkg::unit_cmd_t cmd,
    input  logic [32:0]        dividend,
    output wtdp_pkg::unit_sts_t sts,
    output logic [32:0]        quotient
);
    import wtdp_pkg::*;

    // n / 100 = (n / 4) / 25; 1/25 as ceil(2^36 / 25), exact for any 31-bit n / 4
    localparam logic [31:0] Recip25 = 32'd2748779070;

    logic [30:0] n_reg, n_next;
    logic [62:0] p_reg, p_next;
    logic        run_reg, run_next;

    always_comb
    begin
        n_next   = n_reg;
        p_next   = p_reg;
        run_next = run_reg;
        if (cmd.start)
        begin
            n_next   = dividend[32:2];
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            p_next   = n_reg * Recip25;
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        p_reg <= p_next;
    end

    assign quotient = {6'd0, p_reg[62:36]};
    assign sts.done = !run_reg;

endmodule

// ----- rtl/core/waypoint_turn_drive_planner_core.sv -----
// Channel  | Dir | Handshake            | Payload
// in       | in  | in_valid / in_stall  | in_data   (in_item_t)
// out      | out | out_valid / out_stall| out_data  (out_item_t)
// cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A move frame raises out_valid after these steps, in order: setup, the atan and
// square-root units run side by side, angle and products, two passes through the
// shared divide-by-100 unit (turn time, then drive time), and the output load.
// The next frame can be taken in the same cycle that out_valid rises.  Other
// frames are taken and dropped without a result.
// Reset loads position, heading and config with their defaults and clears all control state.
// in_stall is high while a frame is in work; out_data holds in its register
// until taken, and a following result waits for the output to free up.
module waypoint_turn_drive_planner_core #(
    parameter int CORDIC_STEPS = wtdp_pkg::CordicStepsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wtdp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output wtdp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import wtdp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_RUN   = 4'd2;
    localparam logic [3:0] S_ANGLE = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_DIV2  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_DIV0  = 4'd8;

    logic [3:0] state_reg, state_next;

    // architectural state and config
    logic [9:0]         turn_cfg_reg;
    logic [15:0]        drive_cfg_reg;
    logic [15:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] head_reg;

    // per-transaction work registers
    logic [15:0]        tx_reg, ty_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [15:0] rot_reg, nhead_reg;
    logic [24:0]        tprod_reg;
    logic [47:0]        dprod_reg;
    logic [15:0]        tms_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    unit_cmd_t cordic_cmd, sqrt_cmd, div_cmd;
    unit_sts_t cordic_sts, sqrt_sts, div_sts;
    logic [13:0] angle;
    logic [31:0] root;
    logic [32:0] quot;
    logic [32:0] div_in;
    logic [63:0] radicand;

    logic        accept, frame_ok;
    logic [15:0] mag_x, mag_y;
    logic [32:0] d2;
    logic signed [16:0] gen_head, rot_raw;
    logic signed [15:0] head_c, rot_c;
    logic [14:0] rot_mag;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign frame_ok  = (in_data.start_byte == FRAME_START) &&
                       (in_data.end_byte == FRAME_END) &&
                       (in_data.command_code == CMD_MOVE);

    assign mag_x = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
    assign mag_y = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];
    assign d2    = 33'(mag_x * mag_x) + 33'(mag_y * mag_y);
    // (dx^2 + dy^2) << 30, sampled by the root unit on its start cycle
    assign radicand = {1'b0, d2, 30'd0};

    wtdp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .cmd(cordic_cmd), .mag_x(mag_x), .mag_y(mag_y),
        .sts(cordic_sts), .angle_cdeg(angle)
    );

    wtdp_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .cmd(sqrt_cmd), .radicand(radicand),
        .sts(sqrt_sts), .root(root)
    );

    wtdp_div100 u_div (
        .clk(clk), .rst_n(rst_n), .cmd(div_cmd), .dividend(div_in),
        .sts(div_sts), .quotient(quot)
    );

    // heading and rotation with the axis special cases
    always_comb
    begin
        gen_head = $signed({3'd0, angle});
        if (dx_reg < 0)
            gen_head = 17'sd18000 - gen_head;
        if (dy_reg < 0)
            gen_head = -gen_head;
        if (dx_reg == 0)
        begin
            if (dy_reg < 0)
            begin
                rot_raw = 17'(head_reg) + 17'sd9000;
                head_c  = -16'sd9000;
            end
            else
            begin
                rot_raw = 17'(head_reg) - 17'sd9000;
                head_c  = 16'sd9000;
            end
        end
        else if (dy_reg == 0)
        begin
            if (dx_reg > 0)
                rot_raw = 17'(head_reg);
            else if (head_reg > 0)
                rot_raw = 17'(head_reg) - 17'sd18000;
            else
                rot_raw = 17'(head_reg) + 17'sd18000;
            head_c = (dx_reg > 0) ? 16'sd0 : -16'sd18000;
        end
        else
        begin
            rot_raw = 17'(head_reg) - gen_head;
            if (rot_raw > 17'sd18000)
                rot_raw = rot_raw - 17'sd36000;
            else if (rot_raw < -17'sd18000)
                rot_raw = rot_raw + 17'sd36000;
            head_c = gen_head[15:0];
        end
        rot_c = rot_raw[15:0];
    end

    assign rot_mag = rot_reg[15] ? 15'(-rot_reg) : rot_reg[14:0];
    // turn product goes in first, drive product once the turn time is back
    assign div_in  = (state_reg == S_DIV0) ? {8'd0, tprod_reg} : dprod_reg[47:15];

    always_comb
    begin
        state_next       = state_reg;
        cordic_cmd.start = 1'b0;
        sqrt_cmd.start   = 1'b0;
        div_cmd.start    = 1'b0;
        case (state_reg)
            S_IDLE:
                if (accept && frame_ok)
                    state_next = S_PREP;
            S_PREP:
            begin
                cordic_cmd.start = 1'b1;
                sqrt_cmd.start   = 1'b1;
                state_next       = S_RUN;
            end
            S_RUN:
                if (cordic_sts.done && sqrt_sts.done)
                    state_next = S_ANGLE;
            S_ANGLE:
                state_next = S_MUL;
            S_MUL:
                state_next = S_DIV0;
            S_DIV0:
            begin
                div_cmd.start = 1'b1;
                state_next    = S_DIV1;
            end
            S_DIV1:
                if (div_sts.done)
                begin
                    div_cmd.start = 1'b1;
                    state_next    = S_DIV2;
                end
            S_DIV2:
                if (div_sts.done && !(out_valid_reg && out_stall))
                    state_next = S_OUT;
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            turn_cfg_reg  <= TURN_MS_RESET;
            drive_cfg_reg <= DRIVE_MS_RESET;
            pos_x_reg     <= POS_X_RESET;
            pos_y_reg     <= POS_Y_RESET;
            head_reg      <= HEAD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TURN_MS)
                    turn_cfg_reg <= cfg_data[9:0];
                else if (cfg_index == REG_DRIVE_MS)
                    drive_cfg_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_OUT)
            begin
                out_valid_reg <= 1'b1;
                pos_x_reg     <= tx_reg;
                pos_y_reg     <= ty_reg;
                head_reg      <= nhead_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_reg <= in_data.target_x;
            ty_reg <= in_data.target_y;
            dx_reg <= $signed({1'b0, in_data.target_x}) - $signed({1'b0, pos_x_reg});
            dy_reg <= $signed({1'b0, pos_y_reg}) - $signed({1'b0, in_data.target_y});
        end
        if (state_reg == S_ANGLE)
        begin
            rot_reg   <= rot_c;
            nhead_reg <= head_c;
        end
        if (state_reg == S_MUL)
        begin
            tprod_reg <= turn_cfg_reg * rot_mag;
            dprod_reg <= drive_cfg_reg * root;
        end
        if (state_reg == S_DIV1 && div_sts.done)
            tms_reg <= (quot > 33'd65535) ? 16'hFFFF : quot[15:0];
        if (state_reg == S_OUT)
        begin
            out_reg.rotation_cdeg    <= rot_reg;
            out_reg.turn_ms          <= tms_reg;
            out_reg.drive_ms         <= quot[32] ? 32'hFFFF_FFFF : quot[31:0];
            out_reg.new_heading_cdeg <= nhead_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/core/wtdp_checker.sv -----
module wtdp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input wtdp_pkg::out_item_t out_data,
    input logic                cfg_ready
);
    import wtdp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.new_heading_cdeg >= -16'sd18000) &&
                      (out_data.new_heading_cdeg <= 16'sd18000))
        else $error("heading out of range");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rotation_cdeg >= -16'sd27000) &&
                      (out_data.rotation_cdeg <= 16'sd27000))
        else $error("rotation out of range");

    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in work");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind waypoint_turn_drive_planner_core wtdp_checker u_wtdp_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_ready(cfg_ready)
);
